FILE: hw/rtl/dense_layer_matvec_bias_defines.svh
// Assertion macros for the dense layer matrix-vector block.
`ifndef DENSE_LAYER_MATVEC_BIAS_DEFINES_SVH
`define DENSE_LAYER_MATVEC_BIAS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define DLMV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define DLMV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define DLMV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DLMV_ASSERT(lbl, prop, msg)
`define DLMV_ASSERT_IMP(lbl, ante, cons, msg)
`define DLMV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/dlmv_pkg.sv
// Types and constants of the dense layer matrix-vector block.
package dlmv_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 1024;
	localparam int FRAC_BITS = 8;

	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int WADDR_W  = ROW_W + COL_W;
	localparam int VAL_W    = 16;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_W    = PROD_W + COL_W + 1;
	localparam int RES_W    = 32;
	localparam int ROWS_W   = 7;
	localparam int COLS_W   = 11;
	localparam int CFG_W    = 11;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Register indexes of the configuration port
	typedef enum logic [0:0] {
		REG_ROWS_USED = 1'b0,
		REG_COLS_USED = 1'b1
	} reg_idx_t;

	// Commands carried in tuser of the input request
	typedef enum logic [1:0] {
		CMD_LOAD_BIAS   = 2'd0,
		CMD_LOAD_WEIGHT = 2'd1,
		CMD_LOAD_VECTOR = 2'd2,
		CMD_RUN         = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	// Tags that travel with one multiply-accumulate step
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_tag_t;

endpackage

FILE: hw/rtl/dense_layer_matvec_bias.sv
// Dense layer: matrix-vector multiply with bias over one shared multiply-accumulate unit.
//
// Input requests load bias, weight and vector entries into on-chip memories, one per cycle
// while idle. A run request computes, for each row in order, bias<<8 plus the sum of
// weight*element over cols_used columns (clamped to 1..1024), in signed Q16.16, clipped
// to 32 bits with a saturated flag in tuser; tlast marks the last row. A single 16x16
// multiplier and a 43-bit accumulator are stepped by the sequencer one column per cycle;
// per row it reads the columns, drains the read and multiply stages, then places the
// row result in the output register once that is free. s_tready is low for the whole
// run; the last result may wait in the output register while new loads are taken.
// Stores hold undefined data until written; no clearing pass is made.
`include "dense_layer_matvec_bias_defines.svh"

module dense_layer_matvec_bias (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [dlmv_pkg::CFG_W-1:0]          cfg_data,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: row_index[5:0], col_index[15:6], value[31:16]
	input  logic [dlmv_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tuser: command[1:0]
	input  logic [1:0]                          s_tuser,
	// Output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: out_row[5:0], result_value[37:6], zero padding[39:38]
	output logic [dlmv_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// tuser: saturated[0]
	output logic                                m_tuser,
	output logic                                m_tlast
);

	localparam int ROW_W   = dlmv_pkg::ROW_W;
	localparam int COL_W   = dlmv_pkg::COL_W;
	localparam int WADDR_W = dlmv_pkg::WADDR_W;
	localparam int VAL_W   = dlmv_pkg::VAL_W;
	localparam int PROD_W  = dlmv_pkg::PROD_W;
	localparam int ACC_W   = dlmv_pkg::ACC_W;
	localparam int RES_W   = dlmv_pkg::RES_W;
	localparam int ROWS_W  = dlmv_pkg::ROWS_W;
	localparam int COLS_W  = dlmv_pkg::COLS_W;

	// Memories
	logic [VAL_W-1:0] weight_mem [dlmv_pkg::MAX_ROWS * dlmv_pkg::MAX_COLS];
	logic [VAL_W-1:0] bias_mem   [dlmv_pkg::MAX_ROWS];
	logic [VAL_W-1:0] vector_mem [dlmv_pkg::MAX_COLS];

	// Configuration registers
	logic [ROWS_W-1:0] rows_used_q;
	logic [COLS_W-1:0] cols_used_q;

	// Sequencer state
	dlmv_pkg::state_t state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] nr_last_q;
	logic [COL_W-1:0] nc_last_q;

	// Datapath stages
	dlmv_pkg::mac_tag_t tag_s1, tag_s2, tag_s0;
	logic signed [VAL_W-1:0]  w_s1, v_s1, b_s1, b_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  bias_ext;

	// Output register
	logic             m_tvalid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [RES_W-1:0] out_res_q;
	logic             out_sat_q;
	logic             out_last_q;

	// Decoded input request
	dlmv_pkg::cmd_t   cmd;
	logic [ROW_W-1:0] in_row;
	logic [COL_W-1:0] in_col;
	logic [VAL_W-1:0] in_val;
	logic             in_accept;
	logic             wr_bias, wr_weight, wr_vector, run_start;
	logic             out_load;
	logic             out_free;

	// Saturation of the finished row
	logic [ACC_W-RES_W:0] acc_hi;
	logic                 hi_same;
	logic [RES_W-1:0]     res_clip;
	logic                 res_sat;

	// Effective run lengths
	logic [ROW_W-1:0] nr_last_d;
	logic [COL_W-1:0] nc_last_d;

	assign cmd       = dlmv_pkg::cmd_t'(s_tuser);
	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_col    = s_tdata[ROW_W +: COL_W];
	assign in_val    = s_tdata[ROW_W+COL_W +: VAL_W];
	assign s_tready  = (state_q == dlmv_pkg::ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// Decode the accepted request
	always_comb begin
		wr_bias   = 1'b0;
		wr_weight = 1'b0;
		wr_vector = 1'b0;
		run_start = 1'b0;
		unique case (cmd)
			dlmv_pkg::CMD_LOAD_BIAS:   wr_bias   = in_accept;
			dlmv_pkg::CMD_LOAD_WEIGHT: wr_weight = in_accept;
			dlmv_pkg::CMD_LOAD_VECTOR: wr_vector = in_accept;
			dlmv_pkg::CMD_RUN:         run_start = in_accept;
			default: ;
		endcase
	end

	// Clamp register values to the store sizes
	always_comb begin
		if (rows_used_q == '0) begin
			nr_last_d = '0;
		end else if (rows_used_q > ROWS_W'(dlmv_pkg::MAX_ROWS)) begin
			nr_last_d = ROW_W'(dlmv_pkg::MAX_ROWS - 1);
		end else begin
			nr_last_d = ROW_W'(rows_used_q - ROWS_W'(1));
		end
		if (cols_used_q == '0) begin
			nc_last_d = '0;
		end else if (cols_used_q > COLS_W'(dlmv_pkg::MAX_COLS)) begin
			nc_last_d = COL_W'(dlmv_pkg::MAX_COLS - 1);
		end else begin
			nc_last_d = COL_W'(cols_used_q - COLS_W'(1));
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= ROWS_W'(dlmv_pkg::MAX_ROWS);
			cols_used_q <= COLS_W'(dlmv_pkg::MAX_COLS);
		end else if (cfg_we) begin
			unique case (dlmv_pkg::reg_idx_t'(cfg_index))
				dlmv_pkg::REG_ROWS_USED: rows_used_q <= cfg_data[ROWS_W-1:0];
				dlmv_pkg::REG_COLS_USED: cols_used_q <= cfg_data[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Memories: write from loads, read at the sequencer address
	always_ff @(posedge clk) begin
		if (wr_weight) begin
			weight_mem[{in_row, in_col}] <= in_val;
		end
		w_s1 <= weight_mem[WADDR_W'({row_q, col_q})];
	end

	always_ff @(posedge clk) begin
		if (wr_vector) begin
			vector_mem[in_col] <= in_val;
		end
		v_s1 <= vector_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (wr_bias) begin
			bias_mem[in_row] <= in_val;
		end
		b_s1 <= bias_mem[row_q];
	end

	// Sequencer: next state and control
	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		tag_s0   = '0;
		out_load = 1'b0;
		unique case (state_q)
			dlmv_pkg::ST_IDLE: begin
				if (run_start) begin
					row_d   = '0;
					col_d   = '0;
					state_d = dlmv_pkg::ST_MAC;
				end
			end
			dlmv_pkg::ST_MAC: begin
				tag_s0.valid = 1'b1;
				tag_s0.first = (col_q == '0);
				tag_s0.last  = (col_q == nc_last_q);
				if (col_q == nc_last_q) begin
					state_d = dlmv_pkg::ST_DRAIN;
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			dlmv_pkg::ST_DRAIN: begin
				if (tag_s2.valid && tag_s2.last) begin
					state_d = dlmv_pkg::ST_WRITE;
				end
			end
			dlmv_pkg::ST_WRITE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (row_q == nr_last_q) begin
						state_d = dlmv_pkg::ST_IDLE;
					end else begin
						row_d   = row_q + ROW_W'(1);
						col_d   = '0;
						state_d = dlmv_pkg::ST_MAC;
					end
				end
			end
			default: state_d = dlmv_pkg::ST_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlmv_pkg::ST_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			nr_last_q <= '0;
			nc_last_q <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (run_start) begin
				nr_last_q <= nr_last_d;
				nc_last_q <= nc_last_d;
			end
		end
	end

	// Advance the step tags alongside the read and multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * v_s1;
		b_s2    <= b_s1;
	end

	// Accumulate, starting each row from the aligned bias
	assign bias_ext = ACC_W'(b_s2) <<< dlmv_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= (tag_s2.first ? bias_ext : acc_q) + ACC_W'(prod_s2);
		end
	end

	// Clip the row sum to 32 bits
	assign acc_hi  = acc_q[ACC_W-1:RES_W-1];
	assign hi_same = (acc_hi == '0) || (acc_hi == '1);
	always_comb begin
		res_sat = !hi_same;
		if (hi_same) begin
			res_clip = acc_q[RES_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			res_clip = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			res_clip = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

	// Output register: load a finished row, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= row_q;
			out_res_q  <= res_clip;
			out_sat_q  <= res_sat;
			out_last_q <= (row_q == nr_last_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(dlmv_pkg::OUT_TDATA_W-RES_W-ROW_W){1'b0}}, out_res_q, out_row_q};
	assign m_tuser  = out_sat_q;
	assign m_tlast  = out_last_q;

	// Assertions
	`DLMV_ASSERT_IMP(a_idle_pipe_empty, s_tready, !tag_s1.valid && !tag_s2.valid, "request taken while steps in flight")
	`DLMV_ASSERT_IMP(a_row_end_in_drain, tag_s2.valid && tag_s2.last, state_q == dlmv_pkg::ST_DRAIN, "row end outside drain")
	`DLMV_ASSERT_NEXT(a_last_row_flag, out_load && (row_q == nr_last_q), m_tvalid && m_tlast, "last row not flagged")
	`DLMV_ASSERT_IMP(a_sat_extreme, m_tvalid && m_tuser, (out_res_q == {1'b1, {(RES_W-1){1'b0}}}) || (out_res_q == {1'b0, {(RES_W-1){1'b1}}}), "saturated result not at a limit")
	`DLMV_ASSERT_IMP(a_no_load_when_full, out_load, !m_tvalid_q || m_tready, "result overwritten")

endmodule
